FILE: hdl/mrpt_pkg.sv
`default_nettype none
package mrpt_pkg;
	localparam int BASE_TABLE_LEN = 12;
	localparam int BASE_W = 6;
	localparam logic [BASE_W-1:0] BASE_LIST [BASE_TABLE_LEN] = '{
		6'd2, 6'd3, 6'd5, 6'd7, 6'd11, 6'd13, 6'd17, 6'd19, 6'd23, 6'd29, 6'd31, 6'd37
	};

	typedef struct packed {
		logic load;
		logic start;
		logic [1:0] sel;
	} mrpt_cmd_t;

	typedef struct packed {
		logic busy;
	} mrpt_sts_t;

	localparam logic [1:0] SEL_XB = 2'd0;
	localparam logic [1:0] SEL_BB = 2'd1;
	localparam logic [1:0] SEL_XX = 2'd2;
endpackage
`default_nettype wire

FILE: hdl/mrpt_modmul.sv
`default_nettype none
module mrpt_modmul #(
	parameter int W = 64
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         start,
	input  wire logic [W-1:0] a,
	input  wire logic [W-1:0] b,
	input  wire logic [W-1:0] m,
	output logic              busy,
	output logic [W-1:0]      prod
);
	localparam int CW = $clog2(W + 1);
	logic [W-1:0] acc_q, a_q, b_q;
	logic [CW-1:0] cnt_q;
	logic [W-1:0] dbl, sum;

	function automatic logic [W-1:0] addm(input logic [W-1:0] x, input logic [W-1:0] y,
		input logic [W-1:0] md);
		logic [W-1:0] gap;
		gap = md - y;
		return (x >= gap) ? x - gap : x + y;
	endfunction

	always_comb begin
		dbl = addm(acc_q, acc_q, m);
		sum = b_q[W-1] ? addm(dbl, a_q, m) : dbl;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= CW'(W);
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			acc_q <= '0;
			a_q <= a;
			b_q <= b;
		end else if (cnt_q != '0) begin
			acc_q <= sum;
			b_q <= {b_q[W-2:0], 1'b0};
		end
	end

	assign busy = (cnt_q != '0);
	assign prod = acc_q;
endmodule
`default_nettype wire

FILE: hdl/mrpt_datapath.sv
`default_nettype none
module mrpt_datapath #(
	parameter int W = 64
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire mrpt_pkg::mrpt_cmd_t cmd,
	input  wire logic [W-1:0]      ld_n,
	input  wire logic [W-1:0]      ld_base,
	input  wire logic              ld_x1,
	output mrpt_pkg::mrpt_sts_t    sts,
	output logic [W-1:0]           n_val,
	output logic [W-1:0]           x_val
);
	import mrpt_pkg::*;
	logic [W-1:0] n_q, x_q, b_q, ma, mb, prod;
	logic [1:0] sel_q;
	logic busy, busy_d_q;

	always_comb begin
		unique case (cmd.sel)
			SEL_XB: begin ma = x_q; mb = b_q; end
			SEL_BB: begin ma = b_q; mb = b_q; end
			default: begin ma = x_q; mb = x_q; end
		endcase
	end

	mrpt_modmul #(.W(W)) u_mul (
		.clk(clk), .arst_n(arst_n), .start(cmd.start), .a(ma), .b(mb), .m(n_q),
		.busy(busy), .prod(prod)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_d_q <= 1'b0;
		end else begin
			busy_d_q <= busy;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) sel_q <= cmd.sel;
		if (cmd.load) begin
			n_q <= ld_n;
			b_q <= ld_base;
			x_q <= ld_x1 ? W'(1) : x_q;
		end else if (busy_d_q && !busy) begin
			if (sel_q == SEL_BB) b_q <= prod;
			else x_q <= prod;
		end
	end

	assign sts.busy = busy || (busy_d_q && !busy) || cmd.start;
	assign n_val = n_q;
	assign x_val = x_q;
endmodule
`default_nettype wire

FILE: hdl/mrpt_ctrl.sv
`default_nettype none
module mrpt_ctrl #(
	parameter int W = 64,
	parameter int NUM_BASES = 7
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire logic [W-1:0]      in_n,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output logic                   out_res,
	output mrpt_pkg::mrpt_cmd_t    cmd,
	output logic [W-1:0]           ld_n,
	output logic [W-1:0]           ld_base,
	output logic                   ld_x1,
	input  wire mrpt_pkg::mrpt_sts_t sts,
	input  wire logic [W-1:0]      n_val,
	input  wire logic [W-1:0]      x_val
);
	import mrpt_pkg::*;
	localparam int NB = (NUM_BASES > BASE_TABLE_LEN) ? BASE_TABLE_LEN : NUM_BASES;
	localparam int IW = $clog2(BASE_TABLE_LEN + 1);
	localparam int SW = $clog2(W + 1);
	localparam int DW = $clog2(W);

	typedef enum logic [3:0] {
		S_IDLE, S_MOD3, S_SPLIT, S_BASE, S_EXP, S_EXPW, S_CHK, S_SQ, S_SQW, S_DONE
	} state_t;
	state_t state_q, state_d;
	logic [W-1:0] d_q, n_q, d_d, n_d;
	logic [SW-1:0] s_q, r_q, s_d, r_d;
	logic [IW-1:0] i_q, i_d;
	logic sq_phase_q, sq_phase_d;
	logic [32:0] fold_q, fold_d;
	logic out_valid_d, out_res_d, ld_x1_d;
	mrpt_cmd_t cmd_d;
	logic [W-1:0] nm1;
	logic [BASE_W-1:0] abase;
	logic [63:0] n64;
	logic [17:0] f2;
	logic [10:0] f3;
	logic [7:0] f4;
	logic [4:0] f5;
	logic [3:0] f6;
	logic [2:0] f7;
	logic fold_zero;

	assign nm1 = n_val - 1'b1;
	assign abase = BASE_LIST[i_q[$clog2(BASE_TABLE_LEN)-1:0]];
	assign in_ready = (state_q == S_IDLE) || (state_q == S_DONE && out_ready);
	assign ld_n = n_q;
	assign ld_base = W'(abase);
	assign n64 = 64'(in_n);

	// fold the remainder by three down by powers of four
	always_comb begin
		f2 = {1'b0, fold_q[32:16]} + {2'b0, fold_q[15:0]};
		f3 = {1'b0, f2[17:8]} + {3'b0, f2[7:0]};
		f4 = {1'b0, f3[10:4]} + {4'b0, f3[3:0]};
		f5 = {1'b0, f4[7:4]} + {1'b0, f4[3:0]};
		f6 = {1'b0, f5[4:2]} + {2'b0, f5[1:0]};
		f7 = {1'b0, f6[3:2]} + {1'b0, f6[1:0]};
		fold_zero = (f7 == 3'd0) || (f7 == 3'd3) || (f7 == 3'd6);
	end

	always_comb begin
		state_d = state_q;
		out_valid_d = out_valid;
		out_res_d = out_res;
		cmd_d = '0;
		ld_x1_d = 1'b0;
		n_d = n_q;
		d_d = d_q;
		s_d = s_q;
		r_d = r_q;
		i_d = i_q;
		sq_phase_d = sq_phase_q;
		fold_d = fold_q;
		if (out_valid && out_ready) out_valid_d = 1'b0;
		unique case (state_q)
			S_IDLE, S_DONE: begin
				if (state_q == S_DONE && out_ready) state_d = S_IDLE;
				if (in_valid && in_ready) begin
					n_d = in_n;
					d_d = in_n - 1'b1;
					s_d = '0;
					i_d = '0;
					out_valid_d = 1'b0;
					fold_d = {1'b0, n64[63:32]} + {1'b0, n64[31:0]};
					if (in_n < W'(2)) begin
						out_res_d = 1'b0; state_d = S_DONE; out_valid_d = 1'b1;
					end else if (in_n == W'(2) || in_n == W'(3)) begin
						out_res_d = 1'b1; state_d = S_DONE; out_valid_d = 1'b1;
					end else if (!in_n[0]) begin
						out_res_d = 1'b0; state_d = S_DONE; out_valid_d = 1'b1;
					end else begin
						state_d = S_MOD3;
					end
				end
			end
			S_MOD3: begin
				if (fold_zero) begin
					out_res_d = 1'b0; out_valid_d = 1'b1; state_d = S_DONE;
				end else begin
					state_d = S_SPLIT;
				end
			end
			S_SPLIT: begin
				if (!d_q[0]) begin
					d_d = d_q >> 1;
					s_d = s_q + 1'b1;
				end else begin
					state_d = S_BASE;
				end
			end
			S_BASE: begin
				if (i_q == IW'(NB) || n_q <= W'(abase)) begin
					out_res_d = 1'b1; out_valid_d = 1'b1; state_d = S_DONE;
				end else begin
					cmd_d.load = 1'b1;
					ld_x1_d = 1'b1;
					r_d = '0;
					sq_phase_d = 1'b0;
					state_d = S_EXP;
				end
			end
			S_EXP: begin
				if (r_q == SW'(W)) begin
					state_d = S_CHK;
					r_d = SW'(1);
				end else if (!sq_phase_q && d_q[r_q[DW-1:0]]) begin
					cmd_d.start = 1'b1; cmd_d.sel = SEL_XB; state_d = S_EXPW;
				end else begin
					cmd_d.start = 1'b1; cmd_d.sel = SEL_BB; state_d = S_EXPW;
					sq_phase_d = 1'b1;
				end
			end
			S_EXPW: begin
				if (!sts.busy && !cmd.start) begin
					state_d = S_EXP;
					if (sq_phase_q) begin
						sq_phase_d = 1'b0;
						r_d = r_q + 1'b1;
					end else begin
						sq_phase_d = 1'b1;
					end
				end
			end
			S_CHK: begin
				if (x_val == W'(1) || x_val == nm1) begin
					i_d = i_q + 1'b1; state_d = S_BASE;
				end else begin
					state_d = S_SQ;
				end
			end
			S_SQ: begin
				if (r_q >= s_q) begin
					out_res_d = 1'b0; out_valid_d = 1'b1; state_d = S_DONE;
				end else begin
					cmd_d.start = 1'b1; cmd_d.sel = SEL_XX; state_d = S_SQW;
				end
			end
			S_SQW: begin
				if (!sts.busy && !cmd.start) begin
					r_d = r_q + 1'b1;
					if (x_val == nm1) begin
						i_d = i_q + 1'b1; state_d = S_BASE;
					end else begin
						state_d = S_SQ;
					end
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			out_valid <= 1'b0;
			out_res <= 1'b0;
			cmd <= '0;
			ld_x1 <= 1'b0;
			n_q <= '0;
			d_q <= '0;
			s_q <= '0;
			r_q <= '0;
			i_q <= '0;
			sq_phase_q <= 1'b0;
			fold_q <= '0;
		end else begin
			state_q <= state_d;
			out_valid <= out_valid_d;
			out_res <= out_res_d;
			cmd <= cmd_d;
			ld_x1 <= ld_x1_d;
			n_q <= n_d;
			d_q <= d_d;
			s_q <= s_d;
			r_q <= r_d;
			i_q <= i_d;
			sq_phase_q <= sq_phase_d;
			fold_q <= fold_d;
		end
	end

`ifndef NO_ASSERTIONS
	a_res_done: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> state_q == S_DONE) else $error("result outside done");
	a_no_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_IDLE |-> !cmd.start) else $error("multiply while idle");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_res)) else $error("result lost");
`endif
endmodule
`default_nettype wire

FILE: hdl/miller_rabin_prime_test.sv
`default_nettype none
// Miller-Rabin primality test on one unsigned candidate per item.
// Input channel s_axis: tdata carries candidate in bits NUM_WIDTH-1:0.
// Output channel m_axis: tdata bit 0 carries is_prime.
// One item is worked at a time. Candidates below 4 and even ones answer
// in the cycle after acceptance, odd multiples of three after the S_MOD3
// check. Others take per base NUM_WIDTH squarings, one multiply per set
// bit of the odd part of candidate-1 and up to s-1 further squarings,
// all on the single shift-and-add modular multiplier.
// The result sits in an output register until taken; a new candidate is
// accepted in the cycle the result is taken.
// Reset clears the controller and drops any item at work.
// A stalled receiver holds the result and blocks further input.
module miller_rabin_prime_test #(
	parameter int NUM_WIDTH = 64,
	parameter int NUM_BASES = 7
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   s_axis_tvalid,
	output logic                        s_axis_tready,
	input  wire logic [((NUM_WIDTH+7)/8)*8-1:0] s_axis_tdata, // candidate
	output logic                        m_axis_tvalid,
	input  wire logic                   m_axis_tready,
	output logic [7:0]                  m_axis_tdata  // is_prime
);
	import mrpt_pkg::*;
	mrpt_cmd_t cmd;
	mrpt_sts_t sts;
	logic [NUM_WIDTH-1:0] ld_n, ld_base, n_val, x_val;
	logic ld_x1, res;

	mrpt_ctrl #(.W(NUM_WIDTH), .NUM_BASES(NUM_BASES)) u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
		.in_n(s_axis_tdata[NUM_WIDTH-1:0]), .out_valid(m_axis_tvalid),
		.out_ready(m_axis_tready), .out_res(res), .cmd(cmd), .ld_n(ld_n),
		.ld_base(ld_base), .ld_x1(ld_x1), .sts(sts), .n_val(n_val), .x_val(x_val)
	);

	mrpt_datapath #(.W(NUM_WIDTH)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .ld_n(ld_n), .ld_base(ld_base),
		.ld_x1(ld_x1), .sts(sts), .n_val(n_val), .x_val(x_val)
	);

	assign m_axis_tdata = {7'd0, res};
endmodule
`default_nettype wire

FILE: sim/testbench.sv
`timescale 1ns / 100ps
`default_nettype none
module testbench;
	import mrpt_pkg::*;

	localparam int NUM_WIDTH = 64;
	localparam int NUM_BASES = 7;
	localparam longint CYCLE_LIMIT = 64'd60_000_000;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [63:0] s_axis_tdata;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [7:0]  m_axis_tdata;

	logic   expected_verdicts [$];
	logic [63:0] expected_numbers [$];
	int     error_count;
	longint cycle_count;
	bit     sender_idles;
	bit     receiver_idles;

	miller_rabin_prime_test #(.NUM_WIDTH(NUM_WIDTH), .NUM_BASES(NUM_BASES)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic logic [63:0] mul_mod(logic [63:0] a, logic [63:0] b, logic [63:0] m);
		logic [127:0] p;
		p = ({64'd0, a} * {64'd0, b}) % {64'd0, m};
		return p[63:0];
	endfunction

	function automatic logic [63:0] pow_mod(logic [63:0] a, logic [63:0] e, logic [63:0] m);
		logic [63:0] acc;
		logic [63:0] sq;
		acc = 64'd1;
		sq = a % m;
		while (e != 0) begin
			if (e[0])
				acc = mul_mod(acc, sq, m);
			sq = mul_mod(sq, sq, m);
			e = e >> 1;
		end
		return acc;
	endfunction

	function automatic logic primality_verdict(logic [63:0] n);
		logic [63:0] d;
		logic [63:0] x;
		logic [63:0] a;
		int s;
		int limit;
		bit witness;
		s = 0;
		if (n < 2)
			return 1'b0;
		if (n == 2 || n == 3)
			return 1'b1;
		if (n % 2 == 0 || n % 3 == 0)
			return 1'b0;
		d = n - 1;
		while (!d[0]) begin
			d = d >> 1;
			s++;
		end
		limit = (NUM_BASES > BASE_TABLE_LEN) ? BASE_TABLE_LEN : NUM_BASES;
		for (int i = 0; i < limit; i++) begin
			a = {58'd0, BASE_LIST[i]};
			if (n <= a)
				break;
			x = pow_mod(a, d, n);
			if (x == 1 || x == n - 1)
				continue;
			witness = 1'b1;
			for (int r = 1; r < s; r++) begin
				x = mul_mod(x, x, n);
				if (x == n - 1) begin
					witness = 1'b0;
					break;
				end
			end
			if (witness)
				return 1'b0;
		end
		return 1'b1;
	endfunction

	task automatic send_candidate(logic [63:0] n);
		while (sender_idles && $urandom_range(0, 99) < 31)
			@(negedge clk);
		s_axis_tvalid = 1'b1;
		s_axis_tdata = n;
		do
			@(posedge clk);
		while (!s_axis_tready);
		expected_verdicts.insert(expected_verdicts.size(), primality_verdict(n));
		expected_numbers.insert(expected_numbers.size(), n);
		@(negedge clk);
		s_axis_tvalid = 1'b0;
		s_axis_tdata = {$urandom, $urandom};
	endtask

	task automatic test_small_and_trivial();
		for (int n = 0; n <= 10; n++)
			send_candidate(64'(n));
		send_candidate(64'd25);
		send_candidate(64'd49);
		send_candidate(64'd561);
		send_candidate(64'd7919);
	endtask

	task automatic test_extremes();
		send_candidate(64'hFFFF_FFFF_FFFF_FFFF);
		send_candidate(64'hFFFF_FFFF_FFFF_FFC5);
		send_candidate(64'hFFFF_FFFF_FFFF_FFFE);
		send_candidate(64'h8000_0000_0000_0001);
		send_candidate(64'd3215031751);
		send_candidate(64'd341550071728321);
		send_candidate(64'd4294967291);
		send_candidate(64'd1000000007 * 64'd998244353);
	endtask

	task automatic test_random(int count);
		logic [63:0] n;
		int width;
		for (int i = 0; i < count; i++) begin
			if (i == count / 2) begin
				sender_idles = 1'b0;
				receiver_idles = 1'b0;
			end
			if (i == count / 2 + 15) begin
				sender_idles = 1'b1;
				receiver_idles = 1'b1;
			end
			width = $urandom_range(1, 64);
			n = {$urandom, $urandom};
			if (width < 64)
				n = n & ((64'd1 << width) - 1);
			if ($urandom_range(0, 3) != 0) begin
				n[0] = 1'b1;
				if (n % 3 == 0)
					n = n + 2;
			end
			send_candidate(n);
		end
	endtask

	initial begin
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		error_count = 0;
		sender_idles = 1'b1;
		receiver_idles = 1'b1;
		repeat (12) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_small_and_trivial();
		test_extremes();
		test_random(80);
		while (expected_verdicts.size() != 0)
			@(negedge clk);
		repeat (20) @(negedge clk);
		if (error_count == 0)
			$display("testbench: clean");
		else
			$display("testbench: errors");
		$finish;
	end

	always @(negedge clk)
		m_axis_tready <= receiver_idles ? ($urandom_range(0, 99) >= 31) : 1'b1;

	initial m_axis_tready = 1'b0;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("testbench: errors");
			$finish;
		end
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (expected_verdicts.size() == 0) begin
				$display("%0t: unexpected item, expected none, actual %0d", $time,
					m_axis_tdata[0]);
				error_count <= error_count + 1;
			end else begin
				if (m_axis_tdata[0] !== expected_verdicts[0]) begin
					$display("%0t: candidate %0d is_prime expected %0d, actual %0d",
						$time, expected_numbers[0], expected_verdicts[0],
						m_axis_tdata[0]);
					error_count <= error_count + 1;
				end
				void'(expected_verdicts.pop_front());
				void'(expected_numbers.pop_front());
			end
		end
	end

	initial cycle_count = 0;
endmodule
`default_nettype wire
